>>> design/hbs_pkg.sv
// Shared constants and helpers for the heightmap box smoother.
// No dependencies.
package hbs_pkg;
	localparam int MaxWidth   = 128;
	localparam int MaxLength  = 128;
	localparam int Radius     = 3;
	localparam int ClipLow    = 3;
	localparam int ClipBack   = 4;
	localparam int PassEdge   = 2;
	localparam int Depth      = MaxWidth * MaxLength;
	localparam int AW         = $clog2(Depth);
	localparam int DW         = (MaxWidth > MaxLength) ? MaxWidth : MaxLength;
	localparam int CW         = $clog2(DW + 1);
	localparam int WinSide    = 2 * Radius + 1;
	// window sums: 49 * 2^15 fits in 22 bits signed
	localparam int SW         = 16 + $clog2(WinSide * WinSide) + 1;
	localparam int QW         = 2 * SW;
	localparam int RW         = SW + 1;

	localparam logic [0:0] RegWidth  = 1'b0;
	localparam logic [0:0] RegLength = 1'b1;

	typedef struct packed {
		logic signed [15:0] h;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} point_t;

	typedef struct packed {
		logic start;
		logic [QW-1:0] num;  // magnitude numerator
		logic [SW:0] den;
	} div_req_t;
endpackage

>>> design/hbs_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on hbs_pkg.
module hbs_divider
	import hbs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  div_req_t        req,
	output logic            done,
	output logic [QW-1:0]   quot
);
	localparam int NW = QW;
	localparam int KW = $clog2(NW + 1);
	logic [NW-1:0] num_q;
	logic [NW:0]   rem_q;
	logic [SW:0]   den_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic [NW:0]   trial;

	assign trial = {rem_q[NW-1:0], num_q[NW-1]} - {{(NW-SW){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
				cnt_q  <= KW'(NW);
			end else if (busy_q) begin
				if (!trial[NW]) begin
					rem_q <= trial;
					quot  <= {quot[NW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[NW-1:0], num_q[NW-1]};
					quot  <= {quot[NW-2:0], 1'b0};
				end
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

>>> design/hbs_engine.sv
// Smoothing sequencer: walks the pass, accumulates windows, drives the divider
// and the bitwise square root. Depends on hbs_pkg and hbs_divider.
module hbs_engine
	import hbs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [CW-1:0]  w,
	input  logic [CW-1:0]  l,
	output logic           busy,
	output logic [AW-1:0]  raddr,
	input  point_t         rdata,
	output logic           we,
	output logic [AW-1:0]  waddr,
	output point_t         wdata
);
	typedef enum logic [3:0] {
		IDLE, PT, RD, ACC, SQ, SQRT, DH, DX, DY, DZ, WR
	} state_t;
	state_t state_q;

	logic [CW-1:0] i_q, j_q, y_q, x_q, ylo_q, yhi_q, xlo_q, xhi_q;
	logic [6:0]    cnt_q;
	logic signed [SW-1:0] sh_q, sx_q, sy_q, sz_q;
	logic [QW-1:0] q_q, rem_q, res_q, bit_q;
	logic [1:0]    sel_q;
	logic          pend_q;
	point_t        out_q;
	div_req_t      dreq;
	logic          ddone;
	logic [QW-1:0] dquot;
	logic signed [SW-1:0] cur;
	logic [SW-1:0] mag;
	logic [QW-1:0] sqr;
	logic [QW-1:0] qval;
	logic signed [16:0] sres;

	hbs_divider u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quot(dquot));

	always_comb begin
		unique case (sel_q)
			2'd0: cur = sh_q;
			2'd1: cur = sx_q;
			2'd2: cur = sy_q;
			default: cur = sz_q;
		endcase
	end
	assign mag = cur[SW-1] ? SW'(-cur) : SW'(cur);
	assign sqr = QW'(mag) * QW'(mag);

	always_comb begin
		qval = dquot;
		if (sel_q != 2'd0 && qval > QW'(16384)) qval = QW'(16384);
		sres = cur[SW-1] ? -17'(qval) : 17'(qval);
	end

	assign busy  = (state_q != IDLE);
	assign raddr = AW'(y_q) * AW'(w) + AW'(x_q);
	assign waddr = AW'(i_q) * AW'(w) + AW'(j_q);
	assign we    = (state_q == WR);
	assign wdata = out_q;

	// rounding divide: (2|s|*scale + d) / 2d
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		if (pend_q) begin
			dreq.start = 1'b1;
			if (sel_q == 2'd0) begin
				dreq.num = QW'({mag, 1'b0}) + QW'(cnt_q);
				dreq.den = (SW+1)'({cnt_q, 1'b0});
			end else begin
				dreq.num = QW'({mag, 15'd0}) + res_q;
				dreq.den = (SW+1)'({res_q[SW-1:0], 1'b0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			unique case (state_q)
				IDLE: if (start) begin
					i_q <= CW'(PassEdge);
					j_q <= CW'(PassEdge);
					state_q <= PT;
				end
				PT: begin
					ylo_q <= (i_q < CW'(ClipLow + Radius)) ? CW'(ClipLow) : i_q - CW'(Radius);
					yhi_q <= (i_q + CW'(Radius) > l - CW'(ClipBack)) ? l - CW'(ClipBack)
						: i_q + CW'(Radius);
					xlo_q <= (j_q < CW'(ClipLow + Radius)) ? CW'(ClipLow) : j_q - CW'(Radius);
					xhi_q <= (j_q + CW'(Radius) > w - CW'(ClipBack)) ? w - CW'(ClipBack)
						: j_q + CW'(Radius);
					y_q <= (i_q < CW'(ClipLow + Radius)) ? CW'(ClipLow) : i_q - CW'(Radius);
					x_q <= (j_q < CW'(ClipLow + Radius)) ? CW'(ClipLow) : j_q - CW'(Radius);
					sh_q <= '0; sx_q <= '0; sy_q <= '0; sz_q <= '0;
					cnt_q <= '0;
					state_q <= RD;
				end
				RD: state_q <= ACC;
				ACC: begin
					sh_q <= sh_q + SW'(rdata.h);
					sx_q <= sx_q + SW'(rdata.nx);
					sy_q <= sy_q + SW'(rdata.ny);
					sz_q <= sz_q + SW'(rdata.nz);
					cnt_q <= cnt_q + 1'b1;
					if (x_q == xhi_q) begin
						x_q <= xlo_q;
						if (y_q == yhi_q) begin
							sel_q <= 2'd1;
							q_q <= '0;
							state_q <= SQ;
						end else begin
							y_q <= y_q + 1'b1;
							state_q <= RD;
						end
					end else begin
						x_q <= x_q + 1'b1;
						state_q <= RD;
					end
				end
				SQ: begin
					q_q <= q_q + sqr;
					if (sel_q == 2'd3) begin
						rem_q <= q_q + sqr;
						res_q <= '0;
						bit_q <= QW'(1) << (QW - 2);
						state_q <= SQRT;
					end else sel_q <= sel_q + 1'b1;
				end
				SQRT: begin
					if (bit_q == '0) begin
						sel_q <= 2'd0;
						pend_q <= 1'b1;
						state_q <= DH;
					end else begin
						if (rem_q >= res_q + bit_q) begin
							rem_q <= rem_q - (res_q + bit_q);
							res_q <= (res_q >> 1) + bit_q;
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				DH, DX, DY, DZ: if (ddone) begin
					if (state_q == DH) out_q.h <= sres[15:0];
					else if (q_q == '0) begin
						out_q.nx <= '0; out_q.ny <= '0; out_q.nz <= '0;
					end else if (state_q == DX) out_q.nx <= sres[15:0];
					else if (state_q == DY) out_q.ny <= sres[15:0];
					else out_q.nz <= sres[15:0];
					if (state_q == DZ) state_q <= WR;
					else begin
						sel_q <= sel_q + 1'b1;
						pend_q <= 1'b1;
						state_q <= state_t'(state_q + 1'b1);
					end
				end
				WR: begin
					if (j_q == w - CW'(PassEdge + 1)) begin
						j_q <= CW'(PassEdge);
						if (i_q == l - CW'(PassEdge + 1)) state_q <= IDLE;
						else begin
							i_q <= i_q + 1'b1;
							state_q <= PT;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= PT;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

>>> design/heightmap_box_smoother.sv
// Top level: stream port, APB registers, point memory and smoothing engine.
// Depends on hbs_pkg and hbs_engine.
//  channel | dir | handshake      | word
//  s_*     | in  | tvalid/tready  | action, height, normal x/y/z
//  m_*     | out | tvalid/tready  | height, normal x/y/z; tlast = last_point
//  apb     | in  | psel/penable   | grid_width @0, grid_length @4
// A load is written to memory when accepted; a read first presents the address, then registered data on m_*.
// The first read after a load runs the pass first: per interior point a window
// accumulation, a square root and four divides. A held m_* word blocks s_tready
// until m_tready.
// Reset clears positions and the smoothed flag; memory contents are undefined.
module heightmap_box_smoother
	import hbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // height, normal_x, normal_y, normal_z
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // height, normal_x, normal_y, normal_z
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [7:0] gw_q, gl_q;
	logic [CW-1:0] w, l;
	logic [AW-1:0] lpos_q, rpos_q;
	logic [AW:0]   n;
	logic smoothed_q;
	point_t mem [Depth];
	point_t rd_s1;
	logic   eng_busy, eng_we, eng_start;
	logic [AW-1:0] eng_raddr, eng_waddr, raddr;
	point_t eng_wdata;
	logic   rd_pend_q;
	logic   go_q, last_s1;

	assign pready = 1'b1;
	assign w = (gw_q < 8'd7) ? CW'(7) : (gw_q > 8'(MaxWidth)) ? CW'(MaxWidth) : CW'(gw_q);
	assign l = (gl_q < 8'd7) ? CW'(7) : (gl_q > 8'(MaxLength)) ? CW'(MaxLength) : CW'(gl_q);
	assign n = (AW+1)'(w) * (AW+1)'(l);
	assign prdata = paddr[2] ? {24'd0, gl_q} : {24'd0, gw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 8'd128;
			gl_q <= 8'd128;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == RegLength) gl_q <= pwdata[7:0];
			else gl_q <= gl_q;
			if (paddr[2] == RegWidth) gw_q <= pwdata[7:0];
		end
	end

	logic acc, is_rd;
	logic [AW-1:0] lp, rp;
	assign s_tready = !eng_busy && !eng_start && !rd_pend_q && (!m_tvalid || m_tready);
	assign acc = s_tvalid && s_tready;
	assign is_rd = s_tuser;
	assign lp = ({1'b0, lpos_q} >= n) ? '0 : lpos_q;
	assign rp = ({1'b0, rpos_q} >= n) ? '0 : rpos_q;
	assign eng_start = 1'b0;
	assign raddr = eng_busy ? eng_raddr : rp;

	hbs_engine u_eng (
		.clk, .arst_n, .start(go_q), .w, .l, .busy(eng_busy),
		.raddr(eng_raddr), .rdata(rd_s1), .we(eng_we), .waddr(eng_waddr),
		.wdata(eng_wdata)
	);

	always_ff @(posedge clk) begin
		if (eng_we) mem[eng_waddr] <= eng_wdata;
		else if (acc && !is_rd)
			mem[lp] <= '{s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]};
		// hold the word while the output waits
		if (!m_tvalid || m_tready) rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q <= '0; rpos_q <= '0; smoothed_q <= 1'b0;
			go_q <= 1'b0; rd_pend_q <= 1'b0; m_tvalid <= 1'b0; last_s1 <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (acc && !is_rd) begin
				lpos_q <= ((AW+1)'(lp) + 1'b1 >= n) ? '0 : lp + 1'b1;
				rpos_q <= '0;
				smoothed_q <= 1'b0;
			end else if (acc) begin
				rd_pend_q <= 1'b1;
				if (!smoothed_q) begin
					go_q <= 1'b1;
					smoothed_q <= 1'b1;
				end
			end else if (rd_pend_q && !go_q && !eng_busy) begin
				// address is on the memory port this cycle; data next
				rd_pend_q <= 1'b0;
				m_tvalid <= 1'b1;
				last_s1 <= ({1'b0, rp} == n - 1'b1);
				rpos_q <= ((AW+1)'(rp) + 1'b1 >= n) ? '0 : rp + 1'b1;
			end
		end
	end

	assign m_tdata = {rd_s1.nz, rd_s1.ny, rd_s1.nx, rd_s1.h};
	assign m_tlast = last_s1;
endmodule

>>> test/tb_heightmap_box_smoother.sv
// Testbench for heightmap_box_smoother: loads grids over the stream port, reads them back
// and checks every word against an in-bench model of the smoothing pass or typed directed values.
// Depends on hbs_pkg and the heightmap_box_smoother RTL.
`timescale 1ns / 1ps

module tb_heightmap_box_smoother;
	import hbs_pkg::*;

	localparam logic [2:0] AddrWidth  = {RegWidth, 2'b00};
	localparam logic [2:0] AddrLength = {RegLength, 2'b00};
	localparam bit ActLoad = 1'b0;
	localparam bit ActRead = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	heightmap_box_smoother u_dut (.*);

	typedef struct {
		logic [15:0] h;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        last;
	} grid_pt_t;

	typedef struct {
		bit          act;
		int          cnt;
		bit          rnd;
		logic [15:0] h, nx, ny, nz;
		bit          chk;
		logic [15:0] eh, ex, ey, ez;
	} stim_row_t;

	// model state
	logic [15:0] mem_h [Depth];
	logic [15:0] mem_x [Depth];
	logic [15:0] mem_y [Depth];
	logic [15:0] mem_z [Depth];
	logic [7:0]  cfg_w, cfg_l;
	int          ld_pos, rd_pos;
	bit          smoothed;

	grid_pt_t pending_pts[$];
	int       errors;
	int       items_sent;
	bit       quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_dim(logic [7:0] v, int maxv);
		if (v < 7) return 7;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic longint div_near(longint n, longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (2 * mag + d) / (2 * d);
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] unit_comp(longint s, longint r);
		longint v;
		v = div_near(s * 16384, r);
		if (v > 16384) v = 16384;
		if (v < -16384) v = -16384;
		return v[15:0];
	endfunction

	task automatic box_smooth(int w, int l);
		longint sh, sx, sy, sz, cnt, q, r;
		int at, k;
		for (int i = PassEdge; i < l - PassEdge; i++) begin
			for (int j = PassEdge; j < w - PassEdge; j++) begin
				sh = 0; sx = 0; sy = 0; sz = 0; cnt = 0;
				at = i * w + j;
				for (int x = j - Radius; x <= j + Radius; x++) begin
					if (x < ClipLow || x > w - ClipBack) continue;
					for (int y = i - Radius; y <= i + Radius; y++) begin
						if (y < ClipLow || y > l - ClipBack) continue;
						k = x + w * y;
						sh += longint'($signed(mem_h[k]));
						sx += longint'($signed(mem_x[k]));
						sy += longint'($signed(mem_y[k]));
						sz += longint'($signed(mem_z[k]));
						cnt++;
					end
				end
				if (cnt == 0) begin
					mem_h[at] = '0; mem_x[at] = '0; mem_y[at] = '0; mem_z[at] = '0;
					continue;
				end
				mem_h[at] = 16'(div_near(sh, cnt));
				q = sx * sx + sy * sy + sz * sz;
				if (q == 0) begin
					mem_x[at] = '0; mem_y[at] = '0; mem_z[at] = '0;
				end else begin
					r = longint'(int_sqrt(q));
					mem_x[at] = unit_comp(sx, r);
					mem_y[at] = unit_comp(sy, r);
					mem_z[at] = unit_comp(sz, r);
				end
			end
		end
	endtask

	// advance the model by one accepted word; a read queues its smoothed point
	task automatic model_step(bit act, logic [15:0] h, logic [15:0] x, logic [15:0] y,
			logic [15:0] z, bit chk, grid_pt_t typed);
		int w, l, n, pos;
		grid_pt_t p;
		w = clamp_dim(cfg_w, MaxWidth);
		l = clamp_dim(cfg_l, MaxLength);
		n = w * l;
		if (act == ActLoad) begin
			pos = (ld_pos >= n) ? 0 : ld_pos;
			mem_h[pos] = h; mem_x[pos] = x; mem_y[pos] = y; mem_z[pos] = z;
			ld_pos = (pos + 1 >= n) ? 0 : pos + 1;
			rd_pos = 0;
			smoothed = 1'b0;
		end else begin
			if (!smoothed) begin
				box_smooth(w, l);
				smoothed = 1'b1;
			end
			pos = (rd_pos >= n) ? 0 : rd_pos;
			p.h = mem_h[pos]; p.nx = mem_x[pos]; p.ny = mem_y[pos]; p.nz = mem_z[pos];
			p.last = (pos == n - 1);
			if (chk) begin
				p.h = typed.h; p.nx = typed.nx; p.ny = typed.ny; p.nz = typed.nz;
			end
			rd_pos = (pos + 1 >= n) ? 0 : pos + 1;
			pending_pts.push_back(p);
		end
	endtask

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result side: random backpressure unless quiet, compare against the oldest prediction
	always @(posedge clk) begin
		grid_pt_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pts.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[15:0], 16'h0);
			end else begin
				e = pending_pts.pop_front();
				if (m_tdata[15:0] !== e.h) report_mismatch("height", m_tdata[15:0], e.h);
				if (m_tdata[31:16] !== e.nx) report_mismatch("normal_x", m_tdata[31:16], e.nx);
				if (m_tdata[47:32] !== e.ny) report_mismatch("normal_y", m_tdata[47:32], e.ny);
				if (m_tdata[63:48] !== e.nz) report_mismatch("normal_z", m_tdata[63:48], e.nz);
				if (m_tlast !== e.last) report_mismatch("last", {15'b0, m_tlast}, {15'b0, e.last});
			end
		end
		m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 36);
	end

	task automatic put_word(bit act, logic [15:0] h, logic [15:0] x, logic [15:0] y,
			logic [15:0] z, bit chk, grid_pt_t typed);
		while (!quiet && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {z, y, x, h};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model_step(act, h, x, y, z, chk, typed);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {$urandom() & 32'hFFFF_FF00} | v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == AddrWidth) cfg_w = v;
		else cfg_l = v;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rnd_normal();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	task automatic load_grid(int cnt);
		grid_pt_t none;
		none = '{default: '0};
		for (int i = 0; i < cnt; i++)
			put_word(ActLoad, 16'($urandom()), rnd_normal(), rnd_normal(), rnd_normal(), 0, none);
	endtask

	task automatic read_grid(int cnt);
		grid_pt_t none;
		none = '{default: '0};
		for (int i = 0; i < cnt; i++)
			put_word(ActRead, 16'($urandom()), 16'($urandom()), 16'($urandom()),
				16'($urandom()), 0, none);
	endtask

	stim_row_t directed[] = '{
		// flat grid at the height and normal extremes
		'{ActLoad, 49, 0, 16'h7FFF, 16'h0000, 16'h0000, 16'h4000, 0, 0, 0, 0, 0},
		'{ActRead, 50, 0, 0, 0, 0, 0, 1, 16'h7FFF, 16'h0000, 16'h0000, 16'h4000},
		'{ActLoad, 49, 0, 16'h8000, 16'hC000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0},
		'{ActRead, 2, 0, 0, 0, 0, 0, 1, 16'h8000, 16'hC000, 16'h0000, 16'h0000},
		// zero normals everywhere
		'{ActLoad, 49, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0},
		'{ActRead, 49, 0, 0, 0, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{ActLoad, 49, 0, 16'h0001, 16'h0000, 16'h4000, 16'hC000, 0, 0, 0, 0, 0},
		'{ActRead, 49, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ActLoad, 60, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ActRead, 55, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	initial begin
		grid_pt_t typed;
		int w, l, n, raw;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		errors = 0; items_sent = 0; quiet = 1'b0;
		cfg_w = 8'd128; cfg_l = 8'd128; ld_pos = 0; rd_pos = 0; smoothed = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(AddrWidth, 8'd7);
		reg_write(AddrLength, 8'd3);  // saturates to 7
		foreach (directed[r]) begin
			typed = '{directed[r].eh, directed[r].ex, directed[r].ey, directed[r].ez, 1'b0};
			for (int i = 0; i < directed[r].cnt; i++) begin
				if (directed[r].rnd)
					put_word(directed[r].act, 16'($urandom()), rnd_normal(), rnd_normal(),
						rnd_normal(), 0, typed);
				else
					put_word(directed[r].act, directed[r].h, directed[r].nx, directed[r].ny,
						directed[r].nz, directed[r].chk, typed);
			end
		end
		drain();

		// widest grid with no idling
		quiet = 1'b1;
		reg_write(AddrWidth, 8'd255);
		reg_write(AddrLength, 8'd7);
		load_grid(128 * 7);
		read_grid(40);
		drain();
		quiet = 1'b0;

		while (items_sent < 1600) begin
			raw = $urandom_range(0, 12);
			reg_write(AddrWidth, 8'(raw));
			raw = $urandom_range(0, 12);
			reg_write(AddrLength, 8'(raw));
			w = clamp_dim(cfg_w, MaxWidth);
			l = clamp_dim(cfg_l, MaxLength);
			n = w * l;
			load_grid(n + $urandom_range(0, n / 2));
			read_grid($urandom_range(1, 2 * n));
			if ($urandom_range(2) == 0) begin
				// shrink without reloading: no new pass, read position wraps to 0 only if past the new grid
				drain();
				reg_write(AddrWidth, 8'($urandom_range(0, w)));
				read_grid($urandom_range(1, n));
			end
			drain();
		end

		drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

>>> sim.f
design/hbs_pkg.sv
design/hbs_divider.sv
design/hbs_engine.sv
design/heightmap_box_smoother.sv
test/tb_heightmap_box_smoother.sv
